[hdl/pltrunc_pkg.sv]
// Package for the polyline truncation block: types and constants.
// Used by every module under hdl; depends on nothing.
package pltrunc_pkg;

    localparam int COORD_W = 32;
    localparam int QUAT_W = 16;
    localparam int LIMIT_W = 31;
    localparam int TRAV_W = 40;
    localparam int SQ_W = 2 * COORD_W + 2;
    localparam int SEG_W = COORD_W + 1;
    localparam int PROD_W = 2 * SEG_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd655360;
    localparam logic [TRAV_W-1:0] REMAIN_MIN = 40'd65;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_KEEP = 2'd1,
        PH_DROP = 2'd2,
        PH_PASS = 2'd3
    } phase_t;

    // Sequencing of the back part.
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SQ, S_ADD, S_SQRT, S_DEC, S_DIV, S_E0, S_E1
    } bstate_t;

    // Result beats that one waypoint leaves for emission.
    typedef enum logic [1:0] {
        M_ONE = 2'd0,
        M_TWO = 2'd1,
        M_INT = 2'd2,
        M_NONE = 2'd3
    } mode_t;

    // One waypoint as it travels through the block.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [4*QUAT_W-1:0] q;
        logic fin;
    } point_t;

    // One emitted waypoint.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [4*QUAT_W-1:0] q;
        logic interp;
        logic pend;
        logic rend;
    } result_t;

endpackage

[hdl/pltrunc_front.sv]
// Front part: accepts waypoints and places them, with the limit, in a two-entry queue.
// Depends on pltrunc_pkg.
module pltrunc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pltrunc_pkg::point_t         in_pt,
    input  logic [pltrunc_pkg::LIMIT_W-1:0] limit,
    output logic                        q_valid,
    input  logic                        q_pop,
    output pltrunc_pkg::point_t         q_pt,
    output logic [pltrunc_pkg::LIMIT_W-1:0] q_limit
);
    import pltrunc_pkg::*;

    point_t pt_reg [2];
    logic [LIMIT_W-1:0] lim_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_pt = pt_reg[rp_reg];
    assign q_limit = lim_reg[rp_reg];

    // Queue storage and pointers.
    always_ff @(posedge aclk) begin
        if (push) begin
            pt_reg[wp_reg] <= in_pt;
            lim_reg[wp_reg] <= limit;
        end
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (q_pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

[hdl/pltrunc_back.sv]
// Back part: segment length by serial square root, cut decision and
// serial interpolation divide, then emission through an output register.
// Depends on pltrunc_pkg.
module pltrunc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  pltrunc_pkg::point_t         q_pt,
    input  logic [pltrunc_pkg::LIMIT_W-1:0] q_limit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pltrunc_pkg::result_t        out_res
);
    import pltrunc_pkg::*;

    bstate_t st_reg, st_next;
    phase_t ph_reg;
    logic front_reg;
    logic [TRAV_W-1:0] trav_reg;
    point_t held_reg, cur_reg;
    logic [LIMIT_W-1:0] lim_reg;
    logic [SEG_W-1:0] dxm_reg, dym_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sum_reg;
    logic [SEG_W-1:0] root_reg;
    logic [SEG_W+1:0] rem_reg;
    logic [6:0] cnt_reg;
    logic [TRAV_W-1:0] remain_reg;
    // Interpolation: three dividends share one step loop.
    logic [1:0] axis_reg;
    logic [PROD_W-1:0] num_reg;
    logic [SEG_W:0] dr_reg;
    logic [PROD_W-1:0] quo_reg;
    logic signed [COORD_W-1:0] ix_reg, iy_reg, iz_reg;
    mode_t mode_reg; // emission pattern
    result_t r0_reg, r1_reg, o_reg;
    logic ov_reg;

    logic signed [COORD_W:0] dx, dy;
    logic [SEG_W+1:0] trial, remsh;
    logic [TRAV_W:0] sum_tr;
    logic [SEG_W:0] drsh;
    logic signed [COORD_W:0] da, db;
    logic [SEG_W-1:0] dmag;
    logic signed [COORD_W-1:0] ca;
    logic [PROD_W-1:0] prod;
    logic qbit;
    logic [COORD_W-1:0] qlow;
    logic signed [COORD_W-1:0] cut_val;
    logic fits, remain_pos, int_cut;
    logic [TRAV_W-1:0] remain_val;
    logic out_free, out_load;

    assign out_valid = ov_reg;
    assign out_res = o_reg;
    assign q_pop = (st_reg == S_IDLE) && q_valid;

    assign dx = {cur_reg.x[COORD_W-1], cur_reg.x} - {held_reg.x[COORD_W-1], held_reg.x};
    assign dy = {cur_reg.y[COORD_W-1], cur_reg.y} - {held_reg.y[COORD_W-1], held_reg.y};
    assign remsh = {rem_reg[SEG_W-1:0], sum_reg[SQ_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign sum_tr = {1'b0, trav_reg} + {{(TRAV_W-SEG_W+1){1'b0}}, root_reg};
    assign drsh = {dr_reg[SEG_W-1:0], num_reg[PROD_W-1]};
    assign qbit = (drsh >= {1'b0, root_reg});
    assign qlow = {quo_reg[COORD_W-2:0], qbit};
    assign cut_val = da[COORD_W] ? ca - qlow : ca + qlow;

    // Cut decision: does the segment fit, and is there room for a cut point?
    assign fits = (sum_tr <= {{(TRAV_W-LIMIT_W+1){1'b0}}, lim_reg});
    assign remain_pos = ({1'b0, lim_reg} > trav_reg[LIMIT_W:0]) &&
                        (trav_reg[TRAV_W-1:LIMIT_W+1] == '0);
    assign remain_val = remain_pos ? TRAV_W'({1'b0, lim_reg} - trav_reg[LIMIT_W:0]) : '0;
    assign int_cut = (ph_reg == PH_KEEP) && (lim_reg != '0) && !fits &&
                     (remain_val > REMAIN_MIN) && (root_reg != '0);

    // The output register takes a beat when it is empty or being emptied.
    assign out_free = !ov_reg || out_ready;
    assign out_load = out_free && ((st_reg == S_E0 && mode_reg != M_NONE) || st_reg == S_E1);

    // Operand selection for the current axis of the interpolation.
    always_comb begin
        case (axis_reg)
            2'd0: begin
                ca = held_reg.x;
                da = {cur_reg.x[COORD_W-1], cur_reg.x} - {held_reg.x[COORD_W-1], held_reg.x};
            end
            2'd1: begin
                ca = held_reg.y;
                da = {cur_reg.y[COORD_W-1], cur_reg.y} - {held_reg.y[COORD_W-1], held_reg.y};
            end
            default: begin
                ca = held_reg.z;
                da = {cur_reg.z[COORD_W-1], cur_reg.z} - {held_reg.z[COORD_W-1], held_reg.z};
            end
        endcase
        db = da[COORD_W] ? -da : da;
        dmag = db[SEG_W-1:0];
        // The remaining length does not exceed the limit, so 31 bits carry it.
        prod = {{(PROD_W-SEG_W){1'b0}}, dmag} *
               {{(PROD_W-LIMIT_W){1'b0}}, remain_reg[LIMIT_W-1:0]};
    end

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (q_valid) st_next = S_MUL;
            S_MUL: begin
                if (ph_reg == PH_FIRST || ph_reg == PH_DROP ||
                    ph_reg == PH_PASS || lim_reg == '0) st_next = S_DEC;
                else st_next = S_SQ;
            end
            S_SQ: st_next = S_ADD;
            S_ADD: st_next = S_SQRT;
            S_SQRT: if (cnt_reg == 7'd0) st_next = S_DEC;
            S_DEC: st_next = int_cut ? S_DIV : S_E0;
            S_DIV: if (cnt_reg == 7'd0 && axis_reg == 2'd2) st_next = S_E0;
            S_E0: if (out_free) begin
                if (mode_reg == M_NONE || mode_reg == M_ONE) st_next = S_IDLE;
                else st_next = S_E1;
            end
            S_E1: if (out_free) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // Datapath and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_FIRST;
            trav_reg <= '0;
            front_reg <= 1'b0;
            held_reg <= '0;
        end else begin
            case (st_reg)
                S_IDLE: if (q_valid) begin
                    cur_reg <= q_pt;
                    lim_reg <= q_limit;
                end
                S_MUL: begin
                    dxm_reg <= dx[COORD_W] ? SEG_W'(-dx) : SEG_W'(dx);
                    dym_reg <= dy[COORD_W] ? SEG_W'(-dy) : SEG_W'(dy);
                end
                S_SQ: begin
                    sqx_reg <= {{(SQ_W-SEG_W){1'b0}}, dxm_reg} *
                               {{(SQ_W-SEG_W){1'b0}}, dxm_reg};
                    sqy_reg <= {{(SQ_W-SEG_W){1'b0}}, dym_reg} *
                               {{(SQ_W-SEG_W){1'b0}}, dym_reg};
                    root_reg <= '0;
                    rem_reg <= '0;
                    cnt_reg <= 7'(SQ_W/2 - 1);
                end
                S_ADD: sum_reg <= sqx_reg + sqy_reg;
                // One root bit a cycle, two radicand bits shifted in.
                S_SQRT: begin
                    if (remsh >= trial) begin
                        rem_reg <= remsh - trial;
                        root_reg <= {root_reg[SEG_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= remsh;
                        root_reg <= {root_reg[SEG_W-2:0], 1'b0};
                    end
                    sum_reg <= {sum_reg[SQ_W-3:0], 2'b00};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                S_DEC: begin
                    if (ph_reg == PH_FIRST) begin
                        held_reg <= cur_reg;
                        trav_reg <= '0;
                        front_reg <= 1'b1;
                        if (cur_reg.fin) begin
                            r0_reg <= {cur_reg.x, cur_reg.y, cur_reg.z, cur_reg.q, 3'b011};
                            mode_reg <= M_ONE;
                        end else begin
                            ph_reg <= PH_KEEP;
                            mode_reg <= M_NONE;
                        end
                    end else if (ph_reg == PH_DROP) begin
                        mode_reg <= M_NONE;
                        if (cur_reg.fin) ph_reg <= PH_FIRST;
                    end else if (ph_reg == PH_PASS || lim_reg == '0) begin
                        ph_reg <= cur_reg.fin ? PH_FIRST : PH_PASS;
                        r0_reg <= {held_reg.x, held_reg.y, held_reg.z, held_reg.q, 2'b00,
                                   !cur_reg.fin};
                        r1_reg <= {cur_reg.x, cur_reg.y, cur_reg.z, cur_reg.q, 3'b011};
                        mode_reg <= cur_reg.fin ? M_TWO : M_ONE;
                        held_reg <= cur_reg;
                    end else if (fits) begin
                        trav_reg <= sum_tr[TRAV_W-1:0];
                        front_reg <= 1'b0;
                        ph_reg <= cur_reg.fin ? PH_FIRST : PH_KEEP;
                        r0_reg <= {held_reg.x, held_reg.y, held_reg.z, held_reg.q, 2'b00,
                                   !cur_reg.fin};
                        r1_reg <= {cur_reg.x, cur_reg.y, cur_reg.z, cur_reg.q, 3'b011};
                        mode_reg <= cur_reg.fin ? M_TWO : M_ONE;
                        held_reg <= cur_reg;
                    end else begin
                        remain_reg <= remain_val;
                        if (int_cut) begin
                            mode_reg <= M_INT;
                            axis_reg <= 2'd0;
                            cnt_reg <= 7'(PROD_W);
                            dr_reg <= '0;
                            num_reg <= '0;
                            quo_reg <= '0;
                            ph_reg <= cur_reg.fin ? PH_FIRST : PH_DROP;
                            r0_reg <= {held_reg.x, held_reg.y, held_reg.z, held_reg.q,
                                       3'b000};
                        end else if (front_reg) begin
                            ph_reg <= cur_reg.fin ? PH_FIRST : PH_PASS;
                            r0_reg <= {held_reg.x, held_reg.y, held_reg.z, held_reg.q, 2'b00,
                                       !cur_reg.fin};
                            r1_reg <= {cur_reg.x, cur_reg.y, cur_reg.z, cur_reg.q, 3'b011};
                            mode_reg <= cur_reg.fin ? M_TWO : M_ONE;
                            held_reg <= cur_reg;
                        end else begin
                            r0_reg <= {held_reg.x, held_reg.y, held_reg.z, held_reg.q,
                                       3'b011};
                            mode_reg <= M_ONE;
                            ph_reg <= cur_reg.fin ? PH_FIRST : PH_DROP;
                        end
                    end
                end
                S_DIV: begin
                    // Load the product when the counter is full, then one quotient bit a cycle.
                    if (cnt_reg == 7'(PROD_W)) begin
                        num_reg <= prod;
                        dr_reg <= '0;
                        cnt_reg <= cnt_reg - 7'd1;
                    end else begin
                        dr_reg <= qbit ? drsh - {1'b0, root_reg} : drsh;
                        num_reg <= {num_reg[PROD_W-2:0], 1'b0};
                        if (cnt_reg == 7'd0) begin
                            case (axis_reg)
                                2'd0: ix_reg <= cut_val;
                                2'd1: iy_reg <= cut_val;
                                default: iz_reg <= cut_val;
                            endcase
                            axis_reg <= axis_reg + 2'd1;
                            cnt_reg <= 7'(PROD_W);
                            quo_reg <= '0;
                        end else begin
                            quo_reg <= {quo_reg[PROD_W-2:0], qbit};
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                end
                S_E0: if (out_free) begin
                    if (mode_reg != M_NONE) o_reg <= r0_reg;
                    if (mode_reg == M_INT)
                        r1_reg <= {ix_reg, iy_reg, iz_reg, cur_reg.q, 3'b111};
                end
                S_E1: if (out_free) o_reg <= r1_reg;
                default: ;
            endcase
        end
    end

    // Output beat valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (out_load) ov_reg <= 1'b1;
        else if (out_ready) ov_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
    end
endmodule

[hdl/polyline_truncate_by_length.sv]
// Top level of the polyline truncation block.
// Depends on pltrunc_pkg, pltrunc_front and pltrunc_back.
//
// Waypoints enter on the s_ channel (valid/ready), one beat per waypoint, and the
// truncated path leaves on the m_ channel, zero to two beats per input waypoint;
// run_end marks the last beat caused by one input. The limit is written through
// cfg_valid/cfg_ready/cfg_data and applies to later waypoints; the user must write
// it only while the block is idle, which the block itself does not enforce.
// A two-entry queue lets the front keep taking waypoints while the back works.
// A waypoint that needs a segment length passes in the back through set-up (pop,
// differences, squares, sum), serial square root (one result bit a cycle), the
// decision and emission of its result beats. A cut point adds a serial divide for
// each of x, y and z, which share one divider. Pass-through and dropped waypoints
// skip the square root. An output register holds each result beat; when the receiver
// stalls the back waits and the queue fills, then s_ready falls. Reset clears the
// queue, the output register and the path state, and sets the limit to 10 m.
module polyline_truncate_by_length (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    input  logic        s_final_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [15:0] m_out_qx,
    output logic signed [15:0] m_out_qy,
    output logic signed [15:0] m_out_qz,
    output logic signed [15:0] m_out_qw,
    output logic        m_interpolated,
    output logic        m_path_end,
    output logic        m_run_end
);
    import pltrunc_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    point_t in_pt, q_pt;
    logic [LIMIT_W-1:0] q_limit;
    logic q_valid, q_pop;
    result_t res;

    // Limit register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= LIMIT_RESET;
        else if (cfg_valid) limit_reg <= cfg_data;
    end

    assign in_pt = {s_pos_x, s_pos_y, s_pos_z, s_quat_w, s_quat_z, s_quat_y, s_quat_x,
                    s_final_point};

    pltrunc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_pt(in_pt), .limit(limit_reg), .q_valid(q_valid), .q_pop(q_pop),
        .q_pt(q_pt), .q_limit(q_limit)
    );

    pltrunc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_pt(q_pt), .q_limit(q_limit), .out_valid(m_valid), .out_ready(m_ready),
        .out_res(res)
    );

    assign m_out_x = res.x;
    assign m_out_y = res.y;
    assign m_out_z = res.z;
    assign m_out_qx = res.q[15:0];
    assign m_out_qy = res.q[31:16];
    assign m_out_qz = res.q[47:32];
    assign m_out_qw = res.q[63:48];
    assign m_interpolated = res.interp;
    assign m_path_end = res.pend;
    assign m_run_end = res.rend;
endmodule

[verif/polyline_truncate_by_length_test.sv]
// Self-checking testbench for polyline_truncate_by_length: paths of waypoints are
// driven with random gaps and stalls, and each output beat is checked against a predictor.
// Depends on pltrunc_pkg and the polyline_truncate_by_length RTL.
module polyline_truncate_by_length_test;
    import pltrunc_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [63:0]        q;
        logic               fin;
    } waypoint_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [63:0]        q;
        logic               interp;
        logic               pend;
        logic               rend;
    } cut_point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [30:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [15:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic s_final_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic signed [15:0] m_out_qx, m_out_qy, m_out_qz, m_out_qw;
    logic m_interpolated, m_path_end, m_run_end;

    waypoint_t  waypoints_to_send[$];
    cut_point_t expected_points[$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold = 0;
    int sent_count = 0;
    bit s_taken = 1'b0;

    // Predictor state, a copy of the block's path state.
    logic [30:0]        pred_limit;
    logic signed [31:0] pred_hx, pred_hy, pred_hz;
    logic [63:0]        pred_hq;
    logic [63:0]        pred_travelled;
    phase_t             pred_phase;
    bit                 pred_front_only;

    polyline_truncate_by_length dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .s_quat_w(s_quat_w), .s_final_point(s_final_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_out_qx(m_out_qx), .m_out_qy(m_out_qy), .m_out_qz(m_out_qz),
        .m_out_qw(m_out_qw), .m_interpolated(m_interpolated),
        .m_path_end(m_path_end), .m_run_end(m_run_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Floor of the square root of a sum of two squares, one bit per pass.
    function automatic logic [63:0] planar_root(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | v[2*k +: 2];
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    // Coordinate of the cut point between a and b at remain/seg.
    function automatic logic signed [31:0] cut_coord(logic signed [31:0] a,
            logic signed [31:0] b, logic [63:0] remain, logic [63:0] seg);
        logic signed [63:0] d;
        logic [127:0] m;
        logic [127:0] q;
        d = 64'(b) - 64'(a);
        m = d < 0 ? 128'(-d) : 128'(d);
        q = (m * 128'(remain)) / 128'(seg);
        return d < 0 ? 32'(64'(a) - 64'(q)) : 32'(64'(a) + 64'(q));
    endfunction

    function automatic void push_point(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z, logic [63:0] q, bit interp, bit pend);
        cut_point_t p;
        p.x = x; p.y = y; p.z = z; p.q = q;
        p.interp = interp; p.pend = pend; p.rend = 1'b0;
        expected_points.insert(expected_points.size(), p);
    endfunction

    // Emit the held point, hold the new one and close the path on its last waypoint.
    function automatic void step_on(waypoint_t w);
        push_point(pred_hx, pred_hy, pred_hz, pred_hq, 1'b0, 1'b0);
        pred_hx = w.x; pred_hy = w.y; pred_hz = w.z; pred_hq = w.q;
        if (w.fin) begin
            push_point(w.x, w.y, w.z, w.q, 1'b0, 1'b1);
            pred_phase = PH_FIRST;
        end
    endfunction

    // Work out the output beats that one accepted waypoint causes.
    function automatic void predict_cut(waypoint_t w);
        int n_prior;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [65:0] sq;
        logic [63:0] seg;
        logic [63:0] remain;
        n_prior = expected_points.size();
        if (pred_phase == PH_FIRST) begin
            pred_hx = w.x; pred_hy = w.y; pred_hz = w.z; pred_hq = w.q;
            pred_travelled = '0;
            pred_front_only = 1'b1;
            if (w.fin) push_point(w.x, w.y, w.z, w.q, 1'b0, 1'b1);
            else pred_phase = PH_KEEP;
        end else if (pred_phase == PH_DROP) begin
            if (w.fin) pred_phase = PH_FIRST;
        end else if (pred_phase == PH_PASS || pred_limit == '0) begin
            pred_phase = PH_PASS;
            step_on(w);
        end else begin
            dx = 64'(w.x) - 64'(pred_hx);
            dy = 64'(w.y) - 64'(pred_hy);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
            seg = planar_root(sq);
            if (pred_travelled + seg <= 64'(pred_limit)) begin
                pred_travelled = pred_travelled + seg;
                if (pred_travelled > 64'hFF_FFFF_FFFF) pred_travelled = 64'hFF_FFFF_FFFF;
                pred_front_only = 1'b0;
                step_on(w);
            end else begin
                remain = 64'(pred_limit) > pred_travelled ?
                         64'(pred_limit) - pred_travelled : '0;
                if (remain > 64'(REMAIN_MIN) && seg > 0) begin
                    push_point(pred_hx, pred_hy, pred_hz, pred_hq, 1'b0, 1'b0);
                    push_point(cut_coord(pred_hx, w.x, remain, seg),
                               cut_coord(pred_hy, w.y, remain, seg),
                               cut_coord(pred_hz, w.z, remain, seg), w.q, 1'b1, 1'b1);
                    pred_phase = w.fin ? PH_FIRST : PH_DROP;
                end else if (pred_front_only) begin
                    pred_phase = PH_PASS;
                    step_on(w);
                end else begin
                    push_point(pred_hx, pred_hy, pred_hz, pred_hq, 1'b0, 1'b1);
                    pred_phase = w.fin ? PH_FIRST : PH_DROP;
                end
            end
        end
        if (expected_points.size() > n_prior)
            expected_points[expected_points.size() - 1].rend = 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // Input driver: a new beat is offered only once the previous one has been taken.
    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            if (aresetn && waypoints_to_send.size() > 0 &&
                    $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_pos_x <= waypoints_to_send[0].x;
                s_pos_y <= waypoints_to_send[0].y;
                s_pos_z <= waypoints_to_send[0].z;
                {s_quat_w, s_quat_z, s_quat_y, s_quat_x} <= waypoints_to_send[0].q;
                s_final_point <= waypoints_to_send[0].fin;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness and the long hold-off counter.
    always @(negedge aclk) begin
        m_ready <= aresetn && rx_hold == 0 && $urandom_range(99) >= rx_idle_pct;
    end

    always @(negedge aclk) begin
        if (rx_hold > 0) rx_hold <= rx_hold - 1;
    end

    // Accepted input beats feed the predictor; accepted output beats are checked.
    always @(posedge aclk) begin
        cut_point_t e;
        waypoint_t w;
        s_taken = s_valid && s_ready;
        if (s_taken) begin
            w = waypoints_to_send.pop_front();
            predict_cut(w);
        end
        if (m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("output beat with nothing expected");
            end else begin
                e = expected_points.pop_front();
                if (m_out_x !== e.x) report_mismatch($sformatf("x %h want %h", m_out_x, e.x));
                if (m_out_y !== e.y) report_mismatch($sformatf("y %h want %h", m_out_y, e.y));
                if (m_out_z !== e.z) report_mismatch($sformatf("z %h want %h", m_out_z, e.z));
                if ({m_out_qw, m_out_qz, m_out_qy, m_out_qx} !== e.q)
                    report_mismatch($sformatf("quaternion %h want %h",
                        {m_out_qw, m_out_qz, m_out_qy, m_out_qx}, e.q));
                if (m_interpolated !== e.interp) report_mismatch("interpolated flag");
                if (m_path_end !== e.pend) report_mismatch("path_end flag");
                if (m_run_end !== e.rend) report_mismatch("run_end flag");
            end
        end
    end

    function automatic logic [63:0] random_quat();
        logic [63:0] q;
        for (int i = 0; i < 4; i++)
            q[16*i +: 16] = $urandom_range(9) == 0 ? 16'($urandom) :
                            16'($signed($urandom_range(32768)) - 16384);
        return q;
    endfunction

    task automatic queue_point(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z, bit fin);
        waypoint_t w;
        w.x = x; w.y = y; w.z = z; w.q = random_quat(); w.fin = fin;
        waypoints_to_send.insert(waypoints_to_send.size(), w);
        sent_count++;
    endtask

    // A random-walk path; wide paths use coordinates from the whole range.
    task automatic queue_path(int n, int step_max, bit wide);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        x = $urandom; y = $urandom; z = $urandom;
        if (!wide) begin
            x = $signed(x) >>> 8; y = $signed(y) >>> 8; z = $signed(z) >>> 8;
        end
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                if (wide) begin
                    x = $urandom; y = $urandom; z = $urandom;
                end else begin
                    x = x + $signed($urandom_range(2 * step_max)) - step_max;
                    y = y + $signed($urandom_range(2 * step_max)) - step_max;
                    z = z + $signed($urandom_range(2 * step_max)) - step_max;
                end
            end
            queue_point(x, y, z, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (waypoints_to_send.size() != 0 || expected_points.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_limit(logic [30:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        pred_limit = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int count);
        int r;
        int target;
        target = sent_count + count;
        while (sent_count < target) begin
            r = $urandom_range(99);
            if (r < 80)
                queue_path($urandom_range(1, 12), 1 << $urandom_range(6, 19), 1'b0);
            else if (r < 90)
                queue_path($urandom_range(1, 4), 0, 1'b1);
            else
                queue_point($urandom, $urandom, $urandom, $urandom_range(1));
        end
    endtask

    initial begin
        logic [30:0] limits[7];
        limits = '{31'd655360, 31'd0, 31'h7FFF_FFFF, 31'd50, 31'd196608,
                   31'd1310720, 31'd1};
        pred_limit = LIMIT_RESET;
        pred_hx = '0; pred_hy = '0; pred_hz = '0; pred_hq = '0;
        pred_travelled = '0; pred_phase = PH_FIRST; pred_front_only = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed paths at the reset limit of 10 m.
        tx_idle_pct = 34; rx_idle_pct = 58;
        queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        queue_point(0, 0, 0, 1'b0);
        queue_point(196608, 0, 100, 1'b0);
        queue_point(393216, 0, 200, 1'b1);
        queue_point(0, 0, 0, 1'b0);
        queue_point(1310720, 65536, -65536, 1'b0);
        queue_point(5, 5, 5, 1'b0);
        queue_point(6, 6, 6, 1'b1);
        queue_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        queue_point(77, 77, 77, 1'b0);
        queue_point(77, 77, 77, 1'b0);
        queue_point(77, 77, 77, 1'b1);
        begin
            waypoint_t w;
            w.x = -1; w.y = 1; w.z = -1; w.q = 64'h8000_7FFF_8000_7FFF; w.fin = 1'b1;
            waypoints_to_send.insert(waypoints_to_send.size(), w);
        end

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                wait_drained();
                write_limit(limits[p]);
            end
            if (p == 3 || p == 4) begin
                tx_idle_pct = 58; rx_idle_pct = 34;
            end else if (p >= 5) begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            if (p == 3) rx_hold = 3000;
            queue_random(130);
            if (p == 4) begin
                // The sender stops until every outstanding beat has been received.
                while (waypoints_to_send.size() != 0 || expected_points.size() != 0)
                    @(posedge aclk);
            end
            queue_random(130);
        end
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule

[files.f]
hdl/pltrunc_pkg.sv
hdl/pltrunc_front.sv
hdl/pltrunc_back.sv
hdl/polyline_truncate_by_length.sv
verif/polyline_truncate_by_length_test.sv
